FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL; they vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/lsbse_pkg.sv
package lsbse_pkg;

  // input item kinds
  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_COVER = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // result item kinds
  localparam logic [1:0] OKIND_COVER    = 2'd0;
  localparam logic [1:0] OKIND_MSG      = 2'd1;
  localparam logic [1:0] OKIND_OVERFLOW = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_DEPTH = 2'd1;

  localparam logic       MODE_EXTRACT = 1'b0;
  localparam logic       MODE_EMBED   = 1'b1;
  localparam logic [3:0] DEPTH_RESET  = 4'b0001;

  localparam logic [4:0] BUF_BITS = 5'd16;

  // result sideband: kind in the low bits, underrun flag above
  typedef struct packed {
    logic       underrun;
    logic [1:0] kind;
  } out_user_t;

  // mask of the low n bits, n in 0..16
  function automatic logic [15:0] low_mask(input logic [4:0] n);
    logic [16:0] one;
    one = 17'd1 << n;
    return 16'(one - 17'd1);
  endfunction

endpackage

FILE: src/lsb_stego_embed_extract.sv
// Channel | Dir | Handshake              | Payload
// in      | in  | in_tvalid / in_tready  | tdata: data_byte; tuser: kind
// out     | out | out_tvalid / out_tready| tdata: out_byte; tuser: out_kind, underrun
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while in_tready is high: each accepted item updates the bit state and, when it
// has a result, loads the output register in the same cycle.
// A result appears in the cycle after its item is accepted, from the output register.
// Reset (rst_n low, synchronous) clears all state but the result payload; mode 0, depth 1.
// in_tready drops only while a result sits unaccepted in the output register.
`include "assert_macros.svh"

module lsb_stego_embed_extract (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic [1:0]             in_tuser,   // [1:0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_byte
  output lsbse_pkg::out_user_t   out_tuser,  // [1:0] out_kind, [2] underrun
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data
);
  import lsbse_pkg::*;

  logic        mode_r;
  logic [3:0]  depth_r;
  logic [15:0] buf_r, buf_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ended_r, ended_nxt;
  logic [7:0]  xb_r, xb_nxt;
  logic [3:0]  xc_r, xc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  out_user_t   out_user_r;

  logic        in_accept;
  logic        res_valid;
  logic [7:0]  res_byte;
  out_user_t   res_user;

  logic [3:0]  d;
  logic [4:0]  d5;
  logic [7:0]  dmask;
  logic [4:0]  sh;
  logic [4:0]  gap;
  logic [7:0]  keep;
  logic [7:0]  field;
  logic [4:0]  have;
  logic [15:0] acc;
  logic [3:0]  total;
  logic [3:0]  rest;

  logic        chk_under;
  logic        chk_append;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;

  // effective depth: 0 acts as 1, above 8 acts as 8
  always_comb begin
    if (depth_r == 4'd0) begin
      d = 4'd1;
    end else if (depth_r > 4'd8) begin
      d = 4'd8;
    end else begin
      d = depth_r;
    end
    d5    = {1'b0, d};
    dmask = 8'(low_mask(d5));
  end

  // per-item datapath
  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    xb_nxt    = xb_r;
    xc_nxt    = xc_r;
    res_valid = 1'b0;
    res_byte  = in_tdata;
    res_user  = '{underrun: 1'b0, kind: OKIND_COVER};
    sh        = cnt_r - d5;
    gap       = d5 - cnt_r;
    keep      = dmask & ~8'(low_mask(gap));
    field     = 8'(buf_r >> sh) & dmask;
    have      = {2'b00, xc_r[2:0]};
    acc       = ((16'(xb_r) & low_mask(have)) << d) | 16'(in_tdata & dmask);
    total     = have[3:0] + d;
    rest      = total - 4'd8;

    if (mode_r == MODE_EMBED) begin
      case (in_tuser)
        KIND_MSG: begin
          if (ended_r || cnt_r > BUF_BITS - 5'd8) begin
            res_valid     = 1'b1;
            res_user.kind = OKIND_OVERFLOW;
          end else begin
            buf_nxt = {buf_r[7:0], in_tdata};
            cnt_nxt = cnt_r + 5'd8;
          end
        end
        KIND_END: begin
          ended_nxt = 1'b1;
        end
        KIND_COVER: begin
          res_valid = 1'b1;
          if (cnt_r >= d5) begin
            res_byte = (in_tdata & ~dmask) | field;
            buf_nxt  = buf_r & low_mask(sh);
            cnt_nxt  = sh;
          end else if (!ended_r) begin
            res_user.underrun = 1'b1;
          end else if (cnt_r != 5'd0) begin
            // tail bits go to the top of the carrier field
            res_byte = (in_tdata & ~keep) | (8'(buf_r & low_mask(cnt_r)) << gap);
            buf_nxt  = '0;
            cnt_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (in_tuser == KIND_COVER) begin
      // extract: append carrier bits, emit a byte once eight are held
      if (total >= 4'd8) begin
        res_valid     = 1'b1;
        res_user.kind = OKIND_MSG;
        res_byte      = 8'(acc >> rest);
        xb_nxt        = 8'(acc & low_mask({1'b0, rest}));
        xc_nxt        = rest;
      end else begin
        xb_nxt = acc[7:0];
        xc_nxt = total;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EXTRACT;
      depth_r <= DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[0];
        REG_DEPTH: depth_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      cnt_r       <= '0;
      ended_r     <= 1'b0;
      xb_r        <= '0;
      xc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        buf_r   <= buf_nxt;
        cnt_r   <= cnt_nxt;
        ended_r <= ended_nxt;
        xb_r    <= xb_nxt;
        xc_r    <= xc_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_byte_r <= res_byte;
      out_user_r <= res_user;
    end
  end

  // checker terms
  assign chk_under  = out_tvalid && out_tuser.underrun;
  assign chk_append = in_accept && mode_r == MODE_EMBED && in_tuser == KIND_MSG &&
                      !ended_r && cnt_r <= 5'd8;

  `ASSERT_IMPL(a_underrun_cover, clk, rst_n, chk_under, out_tuser.kind == OKIND_COVER)
  `ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `ASSERT_NEXT(a_msg_appends, clk, rst_n, chk_append, cnt_r == $past(cnt_r) + 5'd8)
  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= BUF_BITS && xc_r < 4'd8)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lsbse_pkg::*;

  // kind 3 is not defined; the block must ignore it
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // register indexes past the last register; writes there are ignored
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  localparam int PHASES = 24;
  localparam int PHASE_ITEMS = 70;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } stego_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] val;
    logic       underrun;
  } stego_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  out_user_t   out_tuser;       // [1:0] out_kind, [2] underrun
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  lsb_stego_embed_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the block's registers and bit state
  logic        cfg_mode = MODE_EXTRACT;
  logic [3:0]  cfg_depth = DEPTH_RESET;
  logic [15:0] emb_buf = '0;
  logic [4:0]  emb_cnt = '0;
  logic        msg_done = 1'b0;
  logic [7:0]  ext_acc = '0;
  logic [3:0]  ext_cnt = '0;

  stego_item_t   stego_items_todo[$];
  stego_result_t stego_outputs_due[$];
  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int err_count = 0;
  int snd_idle_pct = 7;
  int rcv_idle_pct = 77;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int carrier_width(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic logic [15:0] bit_mask(input int n);
    if (n >= 16) return 16'hFFFF;
    return 16'((32'd1 << n) - 32'd1);
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [7:0] v, input logic u);
    stego_result_t r;
    r.kind = k;
    r.val = v;
    r.underrun = u;
    stego_outputs_due.insert(stego_outputs_due.size(), r);
  endtask

  // work out what one accepted item does to the state and what it emits
  task automatic stego_predict(input logic [1:0] kind, input logic [7:0] data);
    int d;
    int gap;
    int total;
    int rest;
    logic [15:0] dmask;
    logic [15:0] field;
    logic [15:0] keep;
    logic [15:0] acc;
    d = carrier_width(cfg_depth);
    dmask = bit_mask(d);
    if (cfg_mode == MODE_EMBED) begin
      case (kind)
        KIND_MSG: begin
          if (msg_done || emb_cnt + 8 > 16) begin
            push_result(OKIND_OVERFLOW, data, 1'b0);
          end else begin
            emb_buf = {emb_buf[7:0], data};
            emb_cnt = emb_cnt + 5'd8;
          end
        end
        KIND_END: msg_done = 1'b1;
        KIND_COVER: begin
          if (emb_cnt >= d) begin
            field = (emb_buf >> (emb_cnt - d)) & dmask;
            emb_cnt = 5'(emb_cnt - d);
            emb_buf = emb_buf & bit_mask(emb_cnt);
            push_result(OKIND_COVER, (data & ~dmask[7:0]) | field[7:0], 1'b0);
          end else if (!msg_done) begin
            push_result(OKIND_COVER, data, 1'b1);
          end else if (emb_cnt == 0) begin
            push_result(OKIND_COVER, data, 1'b0);
          end else begin
            // tail bits go to the top of the carrier field
            gap = d - emb_cnt;
            field = (emb_buf & bit_mask(emb_cnt)) << gap;
            keep = dmask & ~bit_mask(gap);
            emb_cnt = '0;
            emb_buf = '0;
            push_result(OKIND_COVER, (data & ~keep[7:0]) | field[7:0], 1'b0);
          end
        end
        default: ;
      endcase
    end else if (kind == KIND_COVER) begin
      acc = ((16'(ext_acc) & bit_mask(ext_cnt)) << d) | (16'(data) & dmask);
      total = ext_cnt + d;
      if (total >= 8) begin
        rest = total - 8;
        push_result(OKIND_MSG, 8'(acc >> rest), 1'b0);
        ext_acc = 8'(acc & bit_mask(rest));
        ext_cnt = 4'(rest);
      end else begin
        ext_acc = acc[7:0];
        ext_cnt = 4'(total);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_item(input logic [1:0] kind, input logic [7:0] data);
    stego_item_t it;
    it.kind = kind;
    it.data = data;
    stego_items_todo.insert(stego_items_todo.size(), it);
    items_queued++;
  endtask

  // register write; the shadow follows once the write is taken
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MODE) cfg_mode = val[0];
    else if (idx == REG_DEPTH) cfg_depth = val;
    cfg_valid <= 1'b0;
  endtask

  // all items taken and all results seen, then a drain wait for silent items
  task automatic wait_drained;
    do @(posedge clk);
    while (items_taken != items_queued || stego_outputs_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // embed traffic: message bytes paced against cover bytes so the buffer
  // mostly stays in range, with some overflow, underrun and unused kinds
  task automatic gen_embed_items(input int count);
    int d;
    int fill;
    d = carrier_width(cfg_depth);
    fill = emb_cnt;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 2))
          0: add_item(KIND_UNUSED, 8'($urandom));
          1: add_item((fill + 8 > 16) ? KIND_MSG : KIND_UNUSED, 8'($urandom));
          default: add_item((fill < d) ? KIND_COVER : KIND_UNUSED, 8'($urandom));
        endcase
      end else if (fill + 8 <= 16 && (fill < d || $urandom_range(0, 2) == 0)) begin
        add_item(KIND_MSG, 8'($urandom));
        fill += 8;
      end else begin
        add_item(KIND_COVER, 8'($urandom));
        fill -= d;
      end
    end
  endtask

  // extract traffic: mostly cover bytes, some items the block ignores
  task automatic gen_extract_items(input int count);
    logic [1:0] noise_kinds[3];
    noise_kinds = '{KIND_MSG, KIND_END, KIND_UNUSED};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) != 0) add_item(KIND_COVER, 8'($urandom));
      else add_item(noise_kinds[$urandom_range(0, 2)], 8'($urandom));
    end
  endtask

  // end of message: leave a short tail in the buffer, close the message,
  // then send traffic that must pass through or be dropped
  task automatic gen_message_end(input int count);
    int d;
    int fill;
    d = carrier_width(cfg_depth);
    fill = emb_cnt;
    while (fill >= d) begin
      add_item(KIND_COVER, 8'($urandom));
      fill -= d;
    end
    if (fill == 0) begin
      add_item(KIND_MSG, 8'($urandom));
      fill = 8;
      while (fill >= d) begin
        add_item(KIND_COVER, 8'($urandom));
        fill -= d;
      end
    end
    add_item(KIND_END, 8'h00);
    add_item(KIND_COVER, 8'hFF);
    add_item(KIND_COVER, 8'h00);
    add_item(KIND_MSG, 8'hC9);
    add_item(KIND_END, 8'hFF);
    for (int i = 0; i < count; i++) add_item(2'($urandom), 8'($urandom));
  endtask

  // input driver: holds an item until taken, then maybe idles
  always @(posedge clk) begin : driver
    stego_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        stego_predict(in_tuser, in_tdata);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (stego_items_todo.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          nxt = stego_items_todo.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.kind;
          in_tdata <= nxt.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : monitor
    stego_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (stego_outputs_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    out_tuser.kind, out_tdata));
        end else begin
          want = stego_outputs_due.pop_front();
          results_checked++;
          if (out_tuser.kind !== want.kind)
            report_mismatch($sformatf("out_kind got %0d want %0d",
                                      out_tuser.kind, want.kind));
          if (out_tdata !== want.val)
            report_mismatch($sformatf("out_byte got %02h want %02h", out_tdata, want.val));
          if (out_tuser.underrun !== want.underrun)
            report_mismatch($sformatf("underrun got %0b want %0b",
                                      out_tuser.underrun, want.underrun));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int depth_plan[PHASES];
    depth_plan = '{1, 2, 3, 4, 5, 6, 7, 8, 0, 9, 15, 8,
                   1, 5, 3, 7, 2, 6, 4, 8, 12, 1, 8, 3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extract at reset settings: alternating carrier bits give 0xAA
    add_item(KIND_COVER, 8'h01);
    add_item(KIND_COVER, 8'hFE);
    add_item(KIND_COVER, 8'hFF);
    add_item(KIND_COVER, 8'h00);
    add_item(KIND_MSG, 8'hFF);
    add_item(KIND_END, 8'h00);
    add_item(KIND_UNUSED, 8'hC3);
    add_item(KIND_COVER, 8'h81);
    add_item(KIND_COVER, 8'h7E);
    add_item(KIND_COVER, 8'h55);
    add_item(KIND_COVER, 8'hAA);
    wait_drained();

    // spare indexes are ignored; mode value uses bit 0 only; depth 15 acts as 8
    write_reg(REG_SPARE_LO, 4'hF);
    write_reg(REG_SPARE_HI, 4'hF);
    write_reg(REG_MODE, 4'b1111);
    write_reg(REG_DEPTH, 4'd15);
    // fill the buffer, overflow it, drain it, then underrun
    add_item(KIND_MSG, 8'hA5);
    add_item(KIND_MSG, 8'h3C);
    add_item(KIND_MSG, 8'h77);
    add_item(KIND_UNUSED, 8'h00);
    add_item(KIND_COVER, 8'h00);
    add_item(KIND_COVER, 8'hFF);
    add_item(KIND_COVER, 8'h12);
    wait_drained();

    // depth 0 acts as 1
    write_reg(REG_DEPTH, 4'd0);
    add_item(KIND_MSG, 8'h80);
    add_item(KIND_COVER, 8'hFE);
    add_item(KIND_COVER, 8'hFF);
    wait_drained();

    // random phases, alternating mode, the last one closes the message
    for (int p = 0; p < PHASES; p++) begin
      snd_idle_pct = (p < 8) ? 7 : (p < 16) ? 77 : 0;
      rcv_idle_pct = (p < 8) ? 77 : (p < 16) ? 7 : 0;
      write_reg(REG_MODE, {3'($urandom), p[0]});
      write_reg(REG_DEPTH, 4'(depth_plan[p]));
      if (p == PHASES - 1) gen_message_end(40);
      else if (p[0]) gen_embed_items(PHASE_ITEMS);
      else gen_extract_items(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d items over %0d register settings in both modes, depths 0..15;",
             items_taken, PHASES);
    $display("checked %0d results, including overflow, underrun and message end.",
             results_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d items and %0d results outstanding",
             items_queued - items_taken, stego_outputs_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
